// File: rtl/csvx_pkg.sv
package csvx_pkg;

	// Field length (in characters) at which a field faults; one char shorter still converts.
	localparam int MAX_FIELD_CHARS = 10;
	localparam int FLEN_W          = $clog2(MAX_FIELD_CHARS + 1);

	localparam int CHAR_W   = 8;
	localparam int COL_W    = 8;
	localparam int DIGIT_W  = 30;
	localparam int VALUE_W  = 31;
	localparam int SUM_W    = 64;
	localparam int COUNT_W  = 32;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int M_DATA_W = 224;

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [1:0] REG_FIRST_COL  = 2'd0;
	localparam logic [1:0] REG_SECOND_COL = 2'd1;
	localparam logic [1:0] REG_SKIP_HDR   = 2'd2;

	localparam logic [COL_W-1:0] FIRST_COL_RST  = 8'd8;
	localparam logic [COL_W-1:0] SECOND_COL_RST = 8'd9;

	typedef enum logic [1:0] {
		ST_VALID    = 2'd0,
		ST_MISSING  = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_HEADER   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_STOP   = 2'd2,
		PH_HALT   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [COL_W-1:0] first_column;
		logic [COL_W-1:0] second_column;
		logic             skip_header;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] first_value;
		logic [VALUE_W-1:0] second_value;
	} line_res_t;

endpackage

// File: rtl/csvx_cfg_regs.sv
module csvx_cfg_regs
	import csvx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_column  <= FIRST_COL_RST;
			cfg_q.second_column <= SECOND_COL_RST;
			cfg_q.skip_header   <= 1'b1;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_FIRST_COL:  cfg_q.first_column  <= pwdata[COL_W-1:0];
				REG_SECOND_COL: cfg_q.second_column <= pwdata[COL_W-1:0];
				REG_SKIP_HDR:   cfg_q.skip_header   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_FIRST_COL:  prdata = {{(DATA_W-COL_W){1'b0}}, cfg_q.first_column};
			REG_SECOND_COL: prdata = {{(DATA_W-COL_W){1'b0}}, cfg_q.second_column};
			REG_SKIP_HDR:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.skip_header};
			default:        prdata = '0;
		endcase
	end

endmodule

// File: rtl/csvx_field_parse.sv
module csvx_field_parse
	import csvx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              line_end,
	input  cfg_t              cfg,
	output line_res_t         line_res
);

	localparam logic [FLEN_W-1:0] LEN_MAX = FLEN_W'(MAX_FIELD_CHARS);

	logic [COL_W-1:0]   comma_q, comma_d;
	logic [FLEN_W-1:0]  len_q, len_d;
	logic [DIGIT_W-1:0] digit_q, digit_d;
	logic               neg_q, neg_d;
	phase_t             phase_q, phase_d;
	logic [VALUE_W-1:0] first_q, first_d;
	logic [VALUE_W-1:0] second_q, second_d;
	logic [1:0]         found_q, found_d;
	status_t            fault_q, fault_d;
	logic               hdr_q, hdr_d;

	logic [COL_W-1:0]   comma_inc;
	logic [1:0]         hit;
	logic               is_digit, is_blank;
	logic [DIGIT_W-1:0] digit_acc;
	logic [VALUE_W-1:0] field_val;
	logic [FLEN_W-1:0]  len_inc;

	assign comma_inc = comma_q + 1'b1;
	assign hit       = {comma_inc == cfg.second_column, comma_inc == cfg.first_column};
	assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign is_blank  = (char_code == CHAR_SPACE) ||
	                   ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
	// times ten as two shifts, plus the digit; wraps at 30 bits
	assign digit_acc = {digit_q[DIGIT_W-4:0], 3'b000} + {digit_q[DIGIT_W-2:0], 1'b0} +
	                   {{(DIGIT_W-4){1'b0}}, char_code[3:0]};
	assign field_val = neg_q ? (VALUE_W'(0) - {1'b0, digit_q}) : {1'b0, digit_q};
	assign len_inc   = (len_q < LEN_MAX) ? len_q + 1'b1 : len_q;

	always_comb begin
		comma_d  = comma_q;
		len_d    = len_q;
		digit_d  = digit_q;
		neg_d    = neg_q;
		phase_d  = phase_q;
		first_d  = first_q;
		second_d = second_q;
		found_d  = found_q;
		fault_d  = fault_q;
		hdr_d    = hdr_q;
		if (step) begin
			if (line_end) begin
				comma_d  = '0;
				len_d    = '0;
				digit_d  = '0;
				neg_d    = 1'b0;
				phase_d  = PH_LEAD;
				first_d  = '0;
				second_d = '0;
				found_d  = '0;
				fault_d  = ST_VALID;
				hdr_d    = 1'b0;
			end else if (fault_q == ST_VALID && phase_q != PH_HALT) begin
				if (char_code == CHAR_NUL) begin
					phase_d = PH_HALT;
				end else if (char_code == CHAR_COMMA) begin
					// past 255 commas the field keeps running
					if (comma_q != '1) begin
						comma_d = comma_inc;
						if (hit != 2'b00 && len_q == '0) begin
							fault_d = ST_MISSING;
						end else if (hit != 2'b00 && len_q >= LEN_MAX) begin
							fault_d = ST_TOO_LONG;
						end else begin
							if (hit[0]) first_d = field_val;
							if (hit[1]) second_d = field_val;
							found_d = found_q | hit;
							len_d   = '0;
							digit_d = '0;
							neg_d   = 1'b0;
							phase_d = PH_LEAD;
						end
					end
				end else begin
					len_d = len_inc;
					unique case (phase_q)
						PH_LEAD: begin
							if (is_blank) begin
								phase_d = PH_LEAD;
							end else if (char_code == CHAR_PLUS || char_code == CHAR_MINUS) begin
								neg_d   = (char_code == CHAR_MINUS);
								phase_d = PH_DIGITS;
							end else if (is_digit) begin
								phase_d = PH_DIGITS;
								digit_d = digit_acc;
							end else begin
								phase_d = PH_STOP;
							end
						end
						PH_DIGITS: begin
							if (is_digit) digit_d = digit_acc;
							else phase_d = PH_STOP;
						end
						PH_STOP, PH_HALT: phase_d = phase_q;
						default: phase_d = phase_q;
					endcase
				end
			end
		end
	end

	// line summary, meaningful when a line_end item steps
	always_comb begin
		line_res.status       = ST_VALID;
		line_res.first_value  = '0;
		line_res.second_value = '0;
		priority if (hdr_q && cfg.skip_header) begin
			line_res.status = ST_HEADER;
		end else if (fault_q != ST_VALID) begin
			line_res.status = fault_q;
		end else if (found_q != 2'b11) begin
			line_res.status = ST_MISSING;
		end else begin
			line_res.status       = ST_VALID;
			line_res.first_value  = first_q;
			line_res.second_value = second_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_q  <= '0;
			len_q    <= '0;
			digit_q  <= '0;
			neg_q    <= 1'b0;
			phase_q  <= PH_LEAD;
			first_q  <= '0;
			second_q <= '0;
			found_q  <= '0;
			fault_q  <= ST_VALID;
			hdr_q    <= 1'b1;
		end else begin
			comma_q  <= comma_d;
			len_q    <= len_d;
			digit_q  <= digit_d;
			neg_q    <= neg_d;
			phase_q  <= phase_d;
			first_q  <= first_d;
			second_q <= second_d;
			found_q  <= found_d;
			fault_q  <= fault_d;
			hdr_q    <= hdr_d;
		end
	end

endmodule

// File: rtl/csvx_accum.sv
module csvx_accum
	import csvx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  line_res_t          line_res,
	output line_res_t          res,
	output logic [SUM_W-1:0]   first_sum,
	output logic [SUM_W-1:0]   second_sum,
	output logic [COUNT_W-1:0] valid_lines
);

	line_res_t          res_q;
	logic [SUM_W-1:0]   first_sum_q, second_sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   first_ext, second_ext;

	assign first_ext  = {{(SUM_W-VALUE_W){line_res.first_value[VALUE_W-1]}},
	                     line_res.first_value};
	assign second_ext = {{(SUM_W-VALUE_W){line_res.second_value[VALUE_W-1]}},
	                     line_res.second_value};

	always_ff @(posedge clk) begin
		if (load) res_q <= line_res;
	end

	// totals only move when a result loads, so they hold while the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sum_q  <= '0;
			second_sum_q <= '0;
			count_q      <= '0;
		end else if (load && line_res.status == ST_VALID) begin
			first_sum_q  <= first_sum_q + first_ext;
			second_sum_q <= second_sum_q + second_ext;
			if (count_q != '1) count_q <= count_q + 1'b1;
		end
	end

	assign res         = res_q;
	assign first_sum   = first_sum_q;
	assign second_sum  = second_sum_q;
	assign valid_lines = count_q;

endmodule

// File: rtl/csv_two_column_extract_sum_top.sv
// CSV two-field extractor and summer.
// Slave stream: one character per item in s_tdata, s_tlast high marks a
// line-end item (its character is ignored). Master stream: one result per
// line-end item; m_tuser carries the line status, m_tdata the two field
// values and the running sums and valid-line count after this line.
// APB port: reg 0 first column (0x0), reg 1 second column (0x4),
// reg 2 skip header (0x8); pready is always high.
// Throughput: one item per cycle, characters and line ends alike, while the
// sink keeps m_tready high. An accepted line-end item passes the input
// register, then its result loads into the output register.
// The input register feeds the field scanner; the output register holds the
// result until taken, so characters keep flowing while a result waits.
// A line-end item waits in the input register only while the output
// register is full and stalled; s_tready drops then.
// Reset clears line state, sums and count, arms the header skip and loads
// the register defaults; no result is pending after reset.
module csv_two_column_extract_sum_top
	import csvx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] char_code
	input  logic                s_tlast,   // line_end
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [30:0] first_value, [61:31] second_value,
	                                       // [125:62] first_sum, [189:126] second_sum,
	                                       // [221:190] valid_lines, [223:222] zero
	output logic [1:0]          m_tuser,   // [1:0] line_status
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	cfg_t               cfg;
	line_res_t          line_res, res;
	logic [SUM_W-1:0]   first_sum, second_sum;
	logic [COUNT_W-1:0] valid_lines;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              out_free, advance, load, m_valid_q;

	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign load     = advance && last_s1;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	csvx_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	csvx_field_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.line_end  (last_s1),
		.cfg       (cfg),
		.line_res  (line_res)
	);

	csvx_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.line_res    (line_res),
		.res         (res),
		.first_sum   (first_sum),
		.second_sum  (second_sum),
		.valid_lines (valid_lines)
	);

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res.status;
	assign m_tdata  = {2'b00, valid_lines, second_sum, first_sum,
	                   res.second_value, res.first_value};

endmodule

// File: rtl/csvx_checker.sv
module csvx_checker
	import csvx_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [1:0]          m_tuser
);

	// a stalled result stays offered
	a_m_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a free sink never back-pressures the input
	a_s_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with sink ready");

	// field values are zero unless the line is valid
	a_zero_vals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_VALID |-> m_tdata[2*VALUE_W-1:0] == '0)
		else $error("values set on a non-valid line");

	// count of valid lines never goes down between results
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready ##1 m_tvalid |->
		m_tdata[221:190] >= $past(m_tdata[221:190]))
		else $error("valid line count decreased");

endmodule

bind csv_two_column_extract_sum_top csvx_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
